@@ rtl/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared beat types, action and result codes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrs_pkg;

   // Default number of task slots in the table.
   localparam int TASK_SLOTS_DEFAULT = 16;

   // At most this many run results leave for one dispatch request.
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 4;
   localparam int KIND_W   = 2;
   localparam int TICK_W   = 32;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_START    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd5;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ADDED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   task_index;
      logic [TICK_W-1:0]   period_ticks;
   } req_beat_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_beat_type;

endpackage

`default_nettype wire

@@ rtl/periodic_task_ready_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic task ready scheduler
// Table of periodic tasks with a tick counter, ready marking and dispatch.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Add, remove,
// start and stop finish in the cycle they are taken, so busy stays low; an
// add answers with one result beat in the following cycle. A tick request
// walks the allocated slots through the shared elapsed-time compare, one
// slot per cycle, and keeps busy high until the walk is done. A dispatch
// request walks the slots one per cycle from slot 0 up to the last ready
// task and sends one run beat per ready task on the way, at most
// MAX_RESULTS of them. Result beats are shown for exactly one cycle with
// rsp_valid high; the receiver cannot hold them off and must take each one.
// The final beat of a request carries last. Periods and last-run ticks live
// in two small RAMs with a registered read, which sets the one-slot-per-cycle
// pace of the tick walk. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_ready_scheduler #(
   parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire ptrs_pkg::req_beat_type req_beat,
   output      logic                   rsp_valid,
   output      ptrs_pkg::rsp_beat_type rsp_beat
);

   // Index into the slot table, and a pointer wide enough to hold the slot
   // count itself.
   localparam int IdxW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int PtrW  = $clog2(TASK_SLOTS + 1);
   localparam int SlotW = ptrs_pkg::SLOT_W;
   localparam int CntW  = ptrs_pkg::RES_CNT_W;
   localparam int TickW = ptrs_pkg::TICK_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_DISP = 2'd2;

   // Control state.
   logic [1:0]            state_ff,      state_in;
   logic [TickW-1:0]      tick_count_ff, tick_count_in;
   logic [PtrW-1:0]       slots_used_ff, slots_used_in;
   logic [TASK_SLOTS-1:0] active_ff,     active_in;
   logic [TASK_SLOTS-1:0] ready_ff,      ready_in;
   logic [PtrW-1:0]       ptr_ff,        ptr_in;
   logic [CntW-1:0]       res_cnt_ff,    res_cnt_in;
   logic                  rd_valid_ff,   rd_valid_in;
   logic [IdxW-1:0]       rd_idx_ff,     rd_idx_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   ptrs_pkg::rsp_beat_type rsp_beat_ff,  rsp_beat_in;

   // Per-slot decodes.
   logic [TASK_SLOTS-1:0] used_mask;
   logic [TASK_SLOTS-1:0] req_hit;
   logic [TASK_SLOTS-1:0] new_hit;
   logic [TASK_SLOTS-1:0] ptr_hit;
   logic [TASK_SLOTS-1:0] ptr_above;
   logic [TASK_SLOTS-1:0] cand;

   logic req_live;
   logic cand_cur;
   logic cand_more;
   logic disp_last;
   logic table_full;
   logic due;

   // RAM ports.
   logic             rd_en;
   logic [IdxW-1:0]  rd_addr;
   logic [IdxW-1:0]  wr_addr;
   logic             period_wr_en;
   logic             last_run_wr_en;
   logic [TickW-1:0] last_run_wr_data;
   logic [TickW-1:0] period_rd;
   logic [TickW-1:0] last_run_rd;

   ptrs_ram #(
      .WIDTH (TickW),
      .DEPTH (TASK_SLOTS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (period_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_beat.period_ticks),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (period_rd)
   );

   ptrs_ram #(
      .WIDTH (TickW),
      .DEPTH (TASK_SLOTS)
   ) u_last_run_ram (
      .clock   (clock),
      .wr_en   (last_run_wr_en),
      .wr_addr (wr_addr),
      .wr_data (last_run_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (last_run_rd)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // Slot decodes. Every slot compares against the request index, the next
   // free slot and the walk pointer on its own.
   always_comb begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
         used_mask[j] = (PtrW'(j) < slots_used_ff);
         req_hit[j]   = (int'(req_beat.task_index) == j);
         new_hit[j]   = (PtrW'(j) == slots_used_ff);
         ptr_hit[j]   = (PtrW'(j) == ptr_ff);
         ptr_above[j] = (PtrW'(j) > ptr_ff);
      end
   end

   // A task that dispatch would run: allocated, active and ready.
   assign cand       = active_ff & ready_ff & used_mask;
   assign req_live   = |(req_hit & active_ff & used_mask);
   assign cand_cur   = |(cand & ptr_hit);
   assign cand_more  = |(cand & ptr_above);
   assign table_full = (slots_used_ff == PtrW'(TASK_SLOTS));

   // The run beat closes the dispatch when no later task is ready, or when it
   // is the last one allowed for a single dispatch.
   assign disp_last = !cand_more || (res_cnt_ff == CntW'(ptrs_pkg::MAX_RESULTS - 1));

   // Elapsed ticks wrap modulo 2^32 and are compared unsigned.
   assign due = ((tick_count_ff - last_run_rd) >= period_rd);

   assign rd_addr = ptr_ff[IdxW-1:0];
   assign wr_addr = (state_ff == ST_DISP) ? ptr_ff[IdxW-1:0] : slots_used_ff[IdxW-1:0];

   always_comb begin
      state_in         = state_ff;
      tick_count_in    = tick_count_ff;
      slots_used_in    = slots_used_ff;
      active_in        = active_ff;
      ready_in         = ready_ff;
      ptr_in           = ptr_ff;
      res_cnt_in       = res_cnt_ff;
      rd_valid_in      = 1'b0;
      rd_idx_in        = rd_idx_ff;
      rsp_valid_in     = 1'b0;
      rsp_beat_in      = rsp_beat_ff;
      rd_en            = 1'b0;
      period_wr_en     = 1'b0;
      last_run_wr_en   = 1'b0;
      last_run_wr_data = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_beat.action)
                  ptrs_pkg::ACT_ADD: begin
                     rsp_valid_in     = 1'b1;
                     rsp_beat_in.last = 1'b1;
                     if (table_full) begin
                        rsp_beat_in.kind = ptrs_pkg::KIND_FULL;
                        rsp_beat_in.slot = '0;
                     end else begin
                        // The new slot starts idle with a last-run tick of zero.
                        period_wr_en     = 1'b1;
                        last_run_wr_en   = 1'b1;
                        last_run_wr_data = '0;
                        active_in        = active_ff | new_hit;
                        ready_in         = ready_ff & ~new_hit;
                        slots_used_in    = slots_used_ff + PtrW'(1);
                        rsp_beat_in.kind = ptrs_pkg::KIND_ADDED;
                        rsp_beat_in.slot = SlotW'(slots_used_ff);
                     end
                  end
                  ptrs_pkg::ACT_REMOVE: begin
                     if (req_live) begin
                        active_in = active_ff & ~req_hit;
                        ready_in  = ready_ff & ~req_hit;
                     end
                  end
                  ptrs_pkg::ACT_START: begin
                     if (req_live) begin
                        ready_in = ready_ff | req_hit;
                     end
                  end
                  ptrs_pkg::ACT_STOP: begin
                     if (req_live) begin
                        ready_in = ready_ff & ~req_hit;
                     end
                  end
                  ptrs_pkg::ACT_TICK: begin
                     tick_count_in = tick_count_ff + TickW'(1);
                     ptr_in        = '0;
                     state_in      = ST_TICK;
                  end
                  ptrs_pkg::ACT_DISPATCH: begin
                     ptr_in     = '0;
                     res_cnt_in = '0;
                     state_in   = ST_DISP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_TICK: begin
            // Finish the compare for the slot read in the previous cycle.
            if (rd_valid_ff && active_ff[rd_idx_ff] && !ready_ff[rd_idx_ff] && due) begin
               ready_in[rd_idx_ff] = 1'b1;
            end
            // Issue the read for the next allocated slot, or finish.
            if (ptr_ff < slots_used_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = ptr_ff[IdxW-1:0];
               ptr_in      = ptr_ff + PtrW'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_DISP: begin
            if (cand_cur) begin
               rsp_valid_in     = 1'b1;
               rsp_beat_in.kind = ptrs_pkg::KIND_RUN;
               rsp_beat_in.slot = SlotW'(ptr_ff);
               rsp_beat_in.last = disp_last;
               last_run_wr_en   = 1'b1;
               last_run_wr_data = tick_count_ff;
               ready_in         = ready_ff & ~ptr_hit;
               res_cnt_in       = res_cnt_ff + CntW'(1);
               if (disp_last) begin
                  state_in = ST_IDLE;
               end
            end else if (!cand_more) begin
               state_in = ST_IDLE;
            end
            ptr_in = ptr_ff + PtrW'(1);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_count_ff <= '0;
         slots_used_ff <= '0;
         active_ff     <= '0;
         ready_ff      <= '0;
         ptr_ff        <= '0;
         res_cnt_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_count_ff <= tick_count_in;
         slots_used_ff <= slots_used_in;
         active_ff     <= active_in;
         ready_ff      <= ready_in;
         ptr_ff        <= ptr_in;
         res_cnt_ff    <= res_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rsp_beat_ff <= rsp_beat_in;
   end

endmodule

`default_nettype wire

@@ rtl/ptrs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AddrW-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]        wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AddrW-1:0]        rd_addr,
   output      logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ verif/periodic_task_ready_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// Periodic task ready scheduler testbench
// Drives add, remove, start, stop, tick and dispatch requests through the
// start/busy handshake and checks every result beat. Expected beats come
// from a task table predictor kept inside a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_ready_scheduler_tb;
   import ptrs_pkg::*;

   localparam int SLOTS      = TASK_SLOTS_DEFAULT;
   localparam int CYCLE_CAP  = 300000;
   localparam int DRAIN_WAIT = 2 * SLOTS + 8;
   localparam int MAX_SHOWN  = 10;

   // Action codes that the block has to ignore.
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   // The scoreboard keeps its own copy of the task table. Each accepted
   // request beat updates that copy and queues the result beats it causes;
   // each result beat from the block is matched against the oldest one.
   class task_table_scoreboard;
      logic [TICK_W-1:0] tick_now;
      int unsigned       slots_taken;
      bit                active [SLOTS];
      bit                ready [SLOTS];
      logic [TICK_W-1:0] period [SLOTS];
      logic [TICK_W-1:0] last_run [SLOTS];
      rsp_beat_type      awaited [$];
      int unsigned       mismatches;

      function new();
         tick_now    = '0;
         slots_taken = 0;
         mismatches  = 0;
         foreach (active[i]) begin
            active[i]   = 1'b0;
            ready[i]    = 1'b0;
            period[i]   = '0;
            last_run[i] = '0;
         end
      endfunction

      function bit live(int unsigned idx);
         return idx < slots_taken && active[idx];
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("mismatch: %s", msg);
      endfunction

      function void note_request(req_beat_type beat);
         rsp_beat_type r;
         int unsigned  idx;
         int           n;
         idx = beat.task_index;
         n   = 0;
         case (beat.action)
            ACT_ADD: begin
               r.last = 1'b1;
               if (slots_taken >= SLOTS) begin
                  r.kind = KIND_FULL;
                  r.slot = '0;
               end else begin
                  period[slots_taken]   = beat.period_ticks;
                  last_run[slots_taken] = '0;
                  ready[slots_taken]    = 1'b0;
                  active[slots_taken]   = 1'b1;
                  r.kind = KIND_ADDED;
                  r.slot = SLOT_W'(slots_taken);
                  slots_taken++;
               end
               awaited.push_back(r);
            end
            ACT_REMOVE: begin
               if (live(idx)) begin
                  active[idx] = 1'b0;
                  ready[idx]  = 1'b0;
               end
            end
            ACT_START: begin
               if (live(idx))
                  ready[idx] = 1'b1;
            end
            ACT_STOP: begin
               if (live(idx))
                  ready[idx] = 1'b0;
            end
            ACT_TICK: begin
               tick_now = tick_now + 1'b1;
               for (int i = 0; i < slots_taken; i++) begin
                  if (active[i] && !ready[i] && (tick_now - last_run[i]) >= period[i])
                     ready[i] = 1'b1;
               end
            end
            ACT_DISPATCH: begin
               for (int i = 0; i < slots_taken && n < MAX_RESULTS; i++) begin
                  if (active[i] && ready[i]) begin
                     r.kind = KIND_RUN;
                     r.slot = SLOT_W'(i);
                     r.last = 1'b0;
                     awaited.push_back(r);
                     last_run[i] = tick_now;
                     ready[i]    = 1'b0;
                     n++;
                  end
               end
               // The final run beat of this dispatch carries last.
               if (n > 0) begin
                  r = awaited.pop_back();
                  r.last = 1'b1;
                  awaited.push_back(r);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected beat kind=%0d slot=%0d last=%0d",
                           got.kind, got.slot, got.last));
         end else begin
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot || got.last !== want.last)
               flag($sformatf("expected kind=%0d slot=%0d last=%0d, got kind=%0d slot=%0d last=%0d",
                              want.kind, want.slot, want.last,
                              got.kind, got.slot, got.last));
         end
      endfunction

      function void drain_check();
         rsp_beat_type want;
         while (awaited.size() > 0) begin
            want = awaited.pop_front();
            flag($sformatf("missing beat kind=%0d slot=%0d last=%0d",
                           want.kind, want.slot, want.last));
         end
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_beat_type req_beat = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_beat_type rsp_beat;

   task_table_scoreboard sb = new();
   int unsigned          cycles = 0;

   periodic_task_ready_scheduler #(
      .TASK_SLOTS(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake or a lost beat ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Both channels are sampled in one process at the rising edge, where the
   // values read are the ones that were settled before the edge. The result
   // beat is checked before the request beat taken at the same edge is
   // noted, so a stray result can never be paired with a newer request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_result(rsp_beat);
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_beat);
      end
   end

   // Present one request beat and hold it until the block takes it. The
   // caller is always just past a rising edge. When the next beat follows
   // with no gap, start is simply assigned high again, never lowered first.
   task automatic send_beat(input req_beat_type beat);
      start    <= 1'b1;
      req_beat <= beat;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic send_fields(input logic [ACTION_W-1:0] act,
                              input logic [SLOT_W-1:0] idx,
                              input logic [TICK_W-1:0] per);
      req_beat_type b;
      b.action       = act;
      b.task_index   = idx;
      b.period_ticks = per;
      send_beat(b);
   endtask

   // Sender gaps are drawn per cycle, so they land on every phase of a tick
   // walk or a dispatch walk, not only between whole requests.
   task automatic sender_gap(input int unsigned pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Random requests lean on ticks and dispatches, which do the real work,
   // with enough adds to fill the table during the run. Periods are mostly
   // short so that tasks fall ready often; now and then a full-range period
   // keeps a task idle for good. Slot indexes favor allocated slots.
   function automatic req_beat_type random_request();
      req_beat_type b;
      int unsigned  pick;
      pick = $urandom_range(9);
      if (pick < 7)
         b.period_ticks = $urandom_range(4);
      else if (pick < 9)
         b.period_ticks = $urandom_range(30, 5);
      else
         b.period_ticks = $urandom();
      if (sb.slots_taken > 0 && $urandom_range(9) < 7)
         b.task_index = SLOT_W'($urandom_range(sb.slots_taken - 1));
      else
         b.task_index = SLOT_W'($urandom_range(SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 10)
         b.action = ACT_ADD;
      else if (pick < 13)
         b.action = ACT_REMOVE;
      else if (pick < 25)
         b.action = ACT_START;
      else if (pick < 33)
         b.action = ACT_STOP;
      else if (pick < 70)
         b.action = ACT_TICK;
      else if (pick < 94)
         b.action = ACT_DISPATCH;
      else if (pick < 97)
         b.action = ACT_SPARE_6;
      else
         b.action = ACT_SPARE_7;
      return b;
   endfunction

   initial begin : stimulus
      int unsigned idle_pct [4];
      idle_pct = '{0, 69, 0, 18};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: an empty table first, where dispatch and tick
      // must stay silent and commands on unallocated slots do nothing.
      send_fields(ACT_DISPATCH, 4'd0, '0);
      send_fields(ACT_TICK, 4'd0, '0);
      send_fields(ACT_START, 4'd0, '0);
      send_fields(ACT_REMOVE, 4'd15, '1);
      // Period extremes: zero is ready on every tick, all ones never.
      send_fields(ACT_ADD, 4'd0, '0);
      send_fields(ACT_ADD, 4'd0, '1);
      send_fields(ACT_ADD, 4'd0, 32'd1);
      send_fields(ACT_ADD, 4'd0, 32'd3);
      // Nothing is ready yet, so this dispatch gives no beats.
      send_fields(ACT_DISPATCH, 4'd0, '0);
      send_fields(ACT_TICK, 4'd0, '0);
      send_fields(ACT_DISPATCH, 4'd0, '0);
      // Start forces the long-period task ready; stop on an idle task holds.
      send_fields(ACT_START, 4'd1, '0);
      send_fields(ACT_STOP, 4'd3, '0);
      send_fields(ACT_START, 4'd3, '0);
      send_fields(ACT_STOP, 4'd3, '0);
      // Unused action codes are ignored.
      send_fields(ACT_SPARE_6, 4'd15, '1);
      send_fields(ACT_SPARE_7, 4'd15, '1);
      // A removed slot stays dead: start on it must have no effect.
      send_fields(ACT_REMOVE, 4'd3, '0);
      send_fields(ACT_START, 4'd3, '0);
      send_fields(ACT_TICK, 4'd0, '0);
      send_fields(ACT_TICK, 4'd0, '0);
      send_fields(ACT_TICK, 4'd0, '0);
      send_fields(ACT_DISPATCH, 4'd0, '0);

      // Random part in four phases of sender idling. The last phase opens by
      // filling the table and pushing one add past full, so the rest of the
      // run works with a full table and refused adds.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 3) begin
            while (sb.slots_taken < SLOTS)
               send_fields(ACT_ADD, SLOT_W'($urandom()), TICK_W'($urandom_range(6)));
            send_fields(ACT_ADD, SLOT_W'($urandom()), $urandom());
         end
         for (int k = 0; k < 60; k++) begin
            sender_gap(idle_pct[ph]);
            send_beat(random_request());
         end
      end
      start <= 1'b0;

      // Let every awaited beat arrive, then give the block time to show any
      // beat it should not send before the final verdict.
      while (sb.awaited.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      sb.drain_check();
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
